// ===== rtl/tiht_pkg.sv =====
package tiht_pkg;

   localparam int MAX_HOLDS = 16;
   localparam int KEY_BITS = 8;
   localparam int IDX_BITS = (MAX_HOLDS > 1) ? $clog2(MAX_HOLDS) : 1;
   localparam int WALK_BITS = $clog2(MAX_HOLDS + 1);
   localparam int CNT_BITS = $clog2(MAX_HOLDS + 1);
   localparam int NOW_BITS = 48;
   localparam int EXP_BITS = 49;
   localparam int MODE_BITS = 3;
   localparam int ID_BITS = 8;
   localparam int DATA_BITS = 32;
   localparam int HOLDS_OUT_BITS = 5;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_TICK    = 3'd0,
      MODE_HOLD    = 3'd1,
      MODE_START   = 3'd2,
      MODE_STOP    = 3'd3,
      MODE_INVALID = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH,
      ST_REPORT
   } state_type;

   typedef enum logic [1:0] {
      OP_EXPIRE,
      OP_RELEASE,
      OP_HOLD
   } op_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [EXP_BITS-1:0] expiry;
   } entry_type;

   typedef struct packed {
      logic                      running;
      logic                      inhibited;
      logic                      inhibit_changed;
      logic [HOLDS_OUT_BITS-1:0] active_holds;
      logic [DATA_BITS-1:0]      hold_requests;
      logic [DATA_BITS-1:0]      release_requests;
      logic [DATA_BITS-1:0]      expiry_total;
      logic [DATA_BITS-1:0]      invalid_total;
   } result_type;

endpackage

// ===== rtl/tiht_if.sv =====
interface tiht_req_if;
   logic                             valid;
   logic                             ready;
   logic [tiht_pkg::MODE_BITS-1:0]   mode;
   logic [tiht_pkg::ID_BITS-1:0]     controller_id;
   logic [tiht_pkg::DATA_BITS-1:0]   hold_ms;
   logic [tiht_pkg::DATA_BITS-1:0]   invalid_count;

   modport source(output valid, output mode, output controller_id, output hold_ms,
                  output invalid_count, input ready);
   modport sink(input valid, input mode, input controller_id, input hold_ms,
                input invalid_count, output ready);
endinterface

interface tiht_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  running;
   logic                                  inhibited;
   logic                                  inhibit_changed;
   logic [tiht_pkg::HOLDS_OUT_BITS-1:0]   active_holds;
   logic [tiht_pkg::DATA_BITS-1:0]        hold_requests;
   logic [tiht_pkg::DATA_BITS-1:0]        release_requests;
   logic [tiht_pkg::DATA_BITS-1:0]        expiry_total;
   logic [tiht_pkg::DATA_BITS-1:0]        invalid_total;

   modport source(output valid, output running, output inhibited, output inhibit_changed,
                  output active_holds, output hold_requests, output release_requests,
                  output expiry_total, output invalid_total, input ready);
   modport sink(input valid, input running, input inhibited, input inhibit_changed,
                input active_holds, input hold_requests, input release_requests,
                input expiry_total, input invalid_total, output ready);
endinterface

// ===== rtl/tx_inhibit_hold_table_top.sv =====
// Transmit-inhibit hold table.
// The req channel carries one command per transfer: a one millisecond tick, a hold
// or release (zero hold_ms) for a controller, start, stop, or an invalid report.
// Each request transfer yields exactly one rsp transfer with the running and
// inhibited flags, the active hold count and four wrapping event counters.
// Start, stop, invalid reports, unused modes and holds or releases while stopped finish
// at once and go straight to the report step. Ticks, holds and releases walk every table
// entry through the single read port of the entry memory, one entry per cycle, then
// pass through a finish step before the result is reported.
// One item is worked on at a time; req.ready is high whenever the engine is idle,
// so a new item may be taken while the previous result still waits in the output
// register. If the receiver stalls, the finished result of the next item waits
// inside the engine until the output register empties.
// Synchronous reset clears the hold valid bits, the overflow hold, the time
// counter, the running flag and all counters; no memory clearing pass is needed.
module tx_inhibit_hold_table_top (
   input  logic     clock,
   input  logic     reset,
   tiht_req_if.sink req,
   tiht_rsp_if.source rsp
);
   import tiht_pkg::*;

   logic       rsp_free;
   logic       rsp_push;
   result_type eng_data;
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_data_ff, rsp_data_in;

   tiht_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp_free (rsp_free),
      .rsp_push (rsp_push),
      .rsp_data (eng_data)
   );

   assign rsp_free = !rsp_vld_ff || rsp.ready;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_push) begin
         rsp_vld_in = 1'b1;
         rsp_data_in = eng_data;
      end else if (rsp.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_vld_ff;
   assign rsp.running = rsp_data_ff.running;
   assign rsp.inhibited = rsp_data_ff.inhibited;
   assign rsp.inhibit_changed = rsp_data_ff.inhibit_changed;
   assign rsp.active_holds = rsp_data_ff.active_holds;
   assign rsp.hold_requests = rsp_data_ff.hold_requests;
   assign rsp.release_requests = rsp_data_ff.release_requests;
   assign rsp.expiry_total = rsp_data_ff.expiry_total;
   assign rsp.invalid_total = rsp_data_ff.invalid_total;

   a_push_into_free: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> rsp_free)
      else $error("Result pushed while the output register is occupied.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("Request taken while an item is still in progress.");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> rsp.valid)
      else $error("Pushed result is not presented.");

   a_inhibit_needs_run: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.inhibited) |-> rsp.running)
      else $error("Inhibited reported while not running.");
endmodule

// ===== rtl/tiht_mem.sv =====
module tiht_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [tiht_pkg::IDX_BITS-1:0] wr_addr,
   input  tiht_pkg::entry_type           wr_data,
   input  logic [tiht_pkg::IDX_BITS-1:0] rd_addr,
   output tiht_pkg::entry_type           rd_data
);
   import tiht_pkg::*;

   entry_type mem [MAX_HOLDS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/tiht_engine.sv =====
module tiht_engine (
   input  logic                 clock,
   input  logic                 reset,
   tiht_req_if.sink             req,
   input  logic                 rsp_free,
   output logic                 rsp_push,
   output tiht_pkg::result_type rsp_data
);
   import tiht_pkg::*;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [EXP_BITS-1:0]     exp_ff, exp_in;
   logic                    before_ff, before_in;
   logic [WALK_BITS-1:0]    walk_ff, walk_in;
   logic                    proc_vld_ff, proc_vld_in;
   logic [IDX_BITS-1:0]     proc_idx_ff, proc_idx_in;
   logic                    found_ff, found_in;
   logic                    free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]     free_idx_ff, free_idx_in;
   logic [MAX_HOLDS-1:0]    valid_ff, valid_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    spill_vld_ff, spill_vld_in;
   logic [EXP_BITS-1:0]     spill_exp_ff, spill_exp_in;
   logic [NOW_BITS-1:0]     now_ff, now_in;
   logic                    running_ff, running_in;
   logic [DATA_BITS-1:0]    hold_cnt_ff, hold_cnt_in;
   logic [DATA_BITS-1:0]    rel_cnt_ff, rel_cnt_in;
   logic [DATA_BITS-1:0]    exp_cnt_ff, exp_cnt_in;
   logic [DATA_BITS-1:0]    inv_cnt_ff, inv_cnt_in;

   logic                    wr_en;
   logic [IDX_BITS-1:0]     wr_addr;
   entry_type               wr_data;
   logic [IDX_BITS-1:0]     rd_addr;
   entry_type               rd_data;
   logic                    active;
   logic [CNT_BITS:0]       active_sum;

   tiht_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign active = (cnt_ff != '0) || spill_vld_ff;
   assign active_sum = {1'b0, cnt_ff} + (CNT_BITS + 1)'(spill_vld_ff);

   always_comb begin
      rsp_data.running = running_ff;
      rsp_data.inhibited = running_ff && active;
      rsp_data.inhibit_changed = (running_ff && active) != before_ff;
      rsp_data.active_holds = HOLDS_OUT_BITS'(active_sum);
      rsp_data.hold_requests = hold_cnt_ff;
      rsp_data.release_requests = rel_cnt_ff;
      rsp_data.expiry_total = exp_cnt_ff;
      rsp_data.invalid_total = inv_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         proc_vld_ff <= 1'b0;
         valid_ff <= '0;
         cnt_ff <= '0;
         spill_vld_ff <= 1'b0;
         spill_exp_ff <= '0;
         now_ff <= '0;
         running_ff <= 1'b0;
         hold_cnt_ff <= '0;
         rel_cnt_ff <= '0;
         exp_cnt_ff <= '0;
         inv_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         proc_vld_ff <= proc_vld_in;
         valid_ff <= valid_in;
         cnt_ff <= cnt_in;
         spill_vld_ff <= spill_vld_in;
         spill_exp_ff <= spill_exp_in;
         now_ff <= now_in;
         running_ff <= running_in;
         hold_cnt_ff <= hold_cnt_in;
         rel_cnt_ff <= rel_cnt_in;
         exp_cnt_ff <= exp_cnt_in;
         inv_cnt_ff <= inv_cnt_in;
      end
      op_ff <= op_in;
      key_ff <= key_in;
      exp_ff <= exp_in;
      before_ff <= before_in;
      walk_ff <= walk_in;
      proc_idx_ff <= proc_idx_in;
      found_ff <= found_in;
      free_found_ff <= free_found_in;
      free_idx_ff <= free_idx_in;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      key_in = key_ff;
      exp_in = exp_ff;
      before_in = before_ff;
      walk_in = walk_ff;
      proc_vld_in = 1'b0;
      proc_idx_in = proc_idx_ff;
      found_in = found_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      valid_in = valid_ff;
      cnt_in = cnt_ff;
      spill_vld_in = spill_vld_ff;
      spill_exp_in = spill_exp_ff;
      now_in = now_ff;
      running_in = running_ff;
      hold_cnt_in = hold_cnt_ff;
      rel_cnt_in = rel_cnt_ff;
      exp_cnt_in = exp_cnt_ff;
      inv_cnt_in = inv_cnt_ff;
      wr_en = 1'b0;
      wr_addr = proc_idx_ff;
      wr_data = '{key: key_ff, expiry: exp_ff};
      rd_addr = walk_ff[IDX_BITS-1:0];
      req.ready = 1'b0;
      rsp_push = 1'b0;

      if (proc_vld_ff) begin
         unique case (op_ff)
            OP_EXPIRE: begin
               if (valid_ff[proc_idx_ff] &&
                   (rd_data.expiry <= EXP_BITS'(now_ff))) begin
                  valid_in[proc_idx_ff] = 1'b0;
                  cnt_in = cnt_ff - CNT_BITS'(1);
                  exp_cnt_in = exp_cnt_ff + DATA_BITS'(1);
               end
            end
            OP_RELEASE: begin
               if (valid_ff[proc_idx_ff] && (rd_data.key == key_ff)) begin
                  valid_in[proc_idx_ff] = 1'b0;
                  cnt_in = cnt_ff - CNT_BITS'(1);
               end
            end
            OP_HOLD: begin
               if (valid_ff[proc_idx_ff] && (rd_data.key == key_ff)) begin
                  wr_en = 1'b1;
                  found_in = 1'b1;
               end
               if (!valid_ff[proc_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in = proc_idx_ff;
               end
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               key_in = KEY_BITS'(req.controller_id);
               before_in = running_ff && active;
               walk_in = '0;
               found_in = 1'b0;
               free_found_in = 1'b0;
               state_in = ST_REPORT;
               unique case (mode_type'(req.mode))
                  MODE_TICK: begin
                     if (now_ff != '1) begin
                        now_in = now_ff + NOW_BITS'(1);
                     end
                     op_in = OP_EXPIRE;
                     state_in = ST_WALK;
                  end
                  MODE_HOLD: begin
                     if (running_ff) begin
                        state_in = ST_WALK;
                        if (req.hold_ms == '0) begin
                           rel_cnt_in = rel_cnt_ff + DATA_BITS'(1);
                           op_in = OP_RELEASE;
                        end else begin
                           hold_cnt_in = hold_cnt_ff + DATA_BITS'(1);
                           exp_in = EXP_BITS'(now_ff) + EXP_BITS'(req.hold_ms);
                           op_in = OP_HOLD;
                        end
                     end
                  end
                  MODE_START: begin
                     now_in = '0;
                     running_in = 1'b1;
                  end
                  MODE_STOP: begin
                     if (running_ff) begin
                        valid_in = '0;
                        cnt_in = '0;
                        spill_vld_in = 1'b0;
                        running_in = 1'b0;
                     end
                  end
                  MODE_INVALID: begin
                     if (running_ff && (req.invalid_count != '0)) begin
                        inv_cnt_in = inv_cnt_ff + req.invalid_count;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (walk_ff != WALK_BITS'(MAX_HOLDS)) begin
               walk_in = walk_ff + WALK_BITS'(1);
               proc_vld_in = 1'b1;
               proc_idx_in = walk_ff[IDX_BITS-1:0];
            end else if (!proc_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_REPORT;
            unique case (op_ff)
               OP_EXPIRE: begin
                  if (spill_vld_ff && (spill_exp_ff <= EXP_BITS'(now_ff))) begin
                     spill_vld_in = 1'b0;
                     exp_cnt_in = exp_cnt_ff + DATA_BITS'(1);
                  end
               end
               OP_HOLD: begin
                  if (!found_ff) begin
                     if (free_found_ff) begin
                        wr_en = 1'b1;
                        wr_addr = free_idx_ff;
                        valid_in[free_idx_ff] = 1'b1;
                        cnt_in = cnt_ff + CNT_BITS'(1);
                     end else if (!spill_vld_ff || (exp_ff > spill_exp_ff)) begin
                        spill_vld_in = 1'b1;
                        spill_exp_in = exp_ff;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_REPORT: begin
            if (rsp_free) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
